[src/c8x_pkg.sv]
package c8x_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int SCREEN_COLS_DEF = 64;
    localparam int SCREEN_ROWS_DEF = 32;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [1:0] FUNC_EXEC  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_SCRN  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] opcode;
        logic [7:0]  random_byte;
        logic [15:0] key_state;
        logic [11:0] address;
        logic [7:0]  write_value;
    } c8x_cmd_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        waiting_key;
        logic        collision;
        logic [7:0]  read_value;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic        illegal;
    } c8x_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DEC, ST_MEMRD, ST_MEMWAIT, ST_DRAW_RD, ST_DRAW_WAIT,
        ST_DRAW_PIX, ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WAIT, ST_SCR_RD,
        ST_SCR_PIX, ST_CLS, ST_DONE
    } c8x_state_t;

endpackage

[src/chip8_instruction_execute.sv]
// Channel  Ports                      Direction  Handshake
// command  start, busy, cmd           in         accepted when start && !busy
// result   done, rsp                  out        one-cycle strobe, cannot stall
//
// Every item passes the idle (accept) state, the decode state, its walk, then the
// result state: register ops, skips, jumps and RAM writes have no walk, RAM reads
// walk ST_MEMRD and ST_MEMWAIT. Draw walks each sprite row as a RAM read, then a
// read and a write of each of 8 pixels on the one-port screen RAM; 00E0 sweeps every
// pixel, FX33 writes three digits, FX55 stores and FX65 loads one register at a time,
// screen reads fetch one pixel at a time. After reset the screen RAM is cleared one
// pixel a cycle (SCREEN_ROWS * SCREEN_COLS pixels, 2048 by default) with busy high.
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  c8x_cmd_t cmd,
    output logic     busy,
    output logic     done,
    output c8x_rsp_t rsp
);

    localparam int MAW  = $clog2(MEM_BYTES);
    localparam int PIX  = SCREEN_COLS * SCREEN_ROWS;
    localparam int PAW  = $clog2(PIX);
    localparam int CW   = $clog2(SCREEN_COLS);
    localparam int RW   = $clog2(SCREEN_ROWS);
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int BPR  = (SCREEN_COLS + 7) / 8;
    localparam int NSB  = BPR * SCREEN_ROWS;

    c8x_state_t state_reg, state_next;
    c8x_cmd_t   cmd_reg, cmd_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [15:0] i_reg, i_next;
    logic [11:0] pc_reg, pc_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [11:0] stk_reg [STACK_DEPTH];
    logic        stk_we;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic [PAW-1:0] pa_reg, pa_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  row_reg, row_next;
    logic [7:0]  bits_reg, bits_next;
    logic [7:0]  acc_reg, acc_next;
    logic        vf_reg, vf_next;
    logic [1:0]  bcd_reg, bcd_next;
    logic        wait_reg, wait_next, ill_reg, ill_next, coll_reg, coll_next;
    logic [7:0]  rd_reg, rd_next;

    // shared adder
    logic [16:0] add_a, add_b, add_y;

    logic          m_we;
    logic [MAW-1:0] m_wa, m_ra;
    logic [7:0]    m_wd, m_rd;
    logic          f_we, f_wd, f_rd;
    logic [PAW-1:0] f_a;

    c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
    c8x_ram #(.WIDTH(1), .DEPTH(PIX)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_a), .wdata(f_wd), .raddr(f_a), .rdata(f_rd));

    assign add_y = add_a + add_b;

    logic [3:0]  ox, oy, on;
    logic [7:0]  okk, vx, vy;
    logic [11:0] onnn;
    assign ox   = cmd_reg.opcode[11:8];
    assign oy   = cmd_reg.opcode[7:4];
    assign on   = cmd_reg.opcode[3:0];
    assign okk  = cmd_reg.opcode[7:0];
    assign onnn = cmd_reg.opcode[11:0];
    assign vx   = v_reg[ox];
    assign vy   = v_reg[oy];

    // pixel position for draw: (vy+row)%ROWS, (vx+col)%COLS
    logic [8:0]  dsy, dsx;
    logic [RW-1:0] py;
    logic [CW-1:0] px;
    assign dsy = {1'b0, vy} + {5'd0, row_reg};
    assign dsx = {1'b0, vx} + {5'd0, 1'b0, cnt_reg[2:0]};
    assign py  = RW'(dsy % 9'(SCREEN_ROWS));
    assign px  = CW'(dsx % 9'(SCREEN_COLS));

    // screen byte index split
    logic [11:0] srow, scb;
    logic [15:0] scol;
    assign srow = cmd_reg.address / 12'(BPR);
    assign scb  = cmd_reg.address % 12'(BPR);
    assign scol = 16'({scb, 3'b000}) + 16'(cnt_reg[2:0]);

    // highest pressed key
    logic [3:0] key_hi;
    always_comb
    begin
        key_hi = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (cmd_reg.key_state[k])
            begin
                key_hi = 4'(k);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= '0;
            end
            i_reg    <= '0;
            pc_reg   <= '0;
            sp_reg   <= '0;
            dt_reg   <= '0;
            st_reg   <= '0;
            pa_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            i_reg     <= i_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            dt_reg    <= dt_next;
            st_reg    <= st_next;
            pa_reg    <= pa_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        row_reg  <= row_next;
        bits_reg <= bits_next;
        acc_reg  <= acc_next;
        vf_reg   <= vf_next;
        bcd_reg  <= bcd_next;
        wait_reg <= wait_next;
        ill_reg  <= ill_next;
        coll_reg <= coll_next;
        rd_reg   <= rd_next;
        if (stk_we)
        begin
            stk_reg[sp_reg] <= pc_reg;
        end
    end

    // sequencer
    always_comb
    begin
        logic [7:0]  t;
        logic [15:0] bcd_prod;
        logic [3:0]  bcd_dig;
        t = '0;
        bcd_prod = '0;
        bcd_dig = '0;
        state_next = state_reg;
        cmd_next = cmd_reg;
        v_next = v_reg;
        i_next = i_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        dt_next = dt_reg;
        st_next = st_reg;
        pa_next = pa_reg;
        cnt_next = cnt_reg;
        row_next = row_reg;
        bits_next = bits_reg;
        acc_next = acc_reg;
        vf_next = vf_reg;
        bcd_next = bcd_reg;
        wait_next = wait_reg;
        ill_next = ill_reg;
        coll_next = coll_reg;
        rd_next = rd_reg;
        stk_we = 1'b0;
        add_a = '0;
        add_b = '0;
        m_we = 1'b0;
        m_wa = '0;
        m_wd = '0;
        m_ra = '0;
        f_we = 1'b0;
        f_wd = 1'b0;
        f_a  = pa_reg;
        done = 1'b0;
        busy = 1'b1;

        unique case (state_reg)
            ST_CLEAR, ST_CLS:
            begin
                f_we = 1'b1;
                f_wd = 1'b0;
                pa_next = pa_reg + 1'b1;
                if (pa_reg == PAW'(PIX - 1))
                begin
                    pa_next = '0;
                    if (state_reg == ST_CLEAR)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd_next = cmd;
                    wait_next = 1'b0;
                    ill_next = 1'b0;
                    coll_next = 1'b0;
                    rd_next = '0;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                state_next = ST_DONE;
                unique case (cmd_reg.func)
                    FUNC_WRITE:
                    begin
                        m_we = 1'b1;
                        m_wa = MAW'(cmd_reg.address);
                        m_wd = cmd_reg.write_value;
                    end
                    FUNC_READ:
                    begin
                        m_ra = MAW'(cmd_reg.address);
                        state_next = ST_MEMRD;
                    end
                    FUNC_SCRN:
                    begin
                        cnt_next = '0;
                        if (32'(cmd_reg.address) >= NSB)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCR_RD;
                        end
                    end
                    default:
                    begin
                        // pc + 2 by default via shared adder
                        add_a = {5'd0, pc_reg};
                        add_b = 17'd2;
                        unique case (cmd_reg.opcode[15:12])
                            4'h0:
                            begin
                                if (cmd_reg.opcode == 16'h00E0)
                                begin
                                    pa_next = '0;
                                    state_next = ST_CLS;
                                    pc_next = add_y[11:0];
                                end
                                else if (cmd_reg.opcode == 16'h00EE)
                                begin
                                    sp_next = sp_reg - 1'b1;
                                    add_a = {5'd0, stk_reg[sp_reg - 1'b1]};
                                    pc_next = add_y[11:0];
                                end
                                else
                                begin
                                    ill_next = 1'b1;
                                    pc_next = add_y[11:0];
                                end
                            end
                            4'h1: pc_next = onnn;
                            4'h2:
                            begin
                                stk_we = 1'b1;
                                sp_next = sp_reg + 1'b1;
                                pc_next = onnn;
                            end
                            4'h3:
                            begin
                                add_b = (vx == okk) ? 17'd4 : 17'd2;
                                pc_next = add_y[11:0];
                            end
                            4'h4:
                            begin
                                add_b = (vx != okk) ? 17'd4 : 17'd2;
                                pc_next = add_y[11:0];
                            end
                            4'h5, 4'h9:
                            begin
                                if (on != 4'h0)
                                begin
                                    ill_next = 1'b1;
                                end
                                else if ((vx == vy) ^ cmd_reg.opcode[15])
                                begin
                                    add_b = 17'd4;
                                end
                                pc_next = add_y[11:0];
                            end
                            4'h6:
                            begin
                                v_next[ox] = okk;
                                pc_next = add_y[11:0];
                            end
                            4'h7:
                            begin
                                v_next[ox] = vx + okk;
                                pc_next = add_y[11:0];
                            end
                            4'h8:
                            begin
                                pc_next = add_y[11:0];
                                case (on)
                                    4'h0: v_next[ox] = vy;
                                    4'h1: v_next[ox] = vx | vy;
                                    4'h2: v_next[ox] = vx & vy;
                                    4'h3: v_next[ox] = vx ^ vy;
                                    4'h4:
                                    begin
                                        t = vx + vy;
                                        v_next[15] = {7'd0, (9'(vx) + 9'(vy)) > 9'd255};
                                        v_next[ox] = t;
                                    end
                                    4'h5:
                                    begin
                                        v_next[15] = {7'd0, vx > vy};
                                        v_next[ox] = vx - vy;
                                    end
                                    4'h6:
                                    begin
                                        v_next[15] = {7'd0, vx[0]};
                                        v_next[ox] = {1'b0, vx[7:1]};
                                    end
                                    4'h7:
                                    begin
                                        v_next[15] = {7'd0, vy > vx};
                                        v_next[ox] = vy - vx;
                                    end
                                    4'hE:
                                    begin
                                        v_next[15] = {7'd0, vx[7]};
                                        v_next[ox] = {vx[6:0], 1'b0};
                                    end
                                    default: ill_next = 1'b1;
                                endcase
                            end
                            4'hA:
                            begin
                                i_next = {4'd0, onnn};
                                pc_next = add_y[11:0];
                            end
                            4'hB:
                            begin
                                add_a = {5'd0, onnn};
                                add_b = {9'd0, v_reg[0]};
                                pc_next = add_y[11:0];
                            end
                            4'hC:
                            begin
                                v_next[ox] = cmd_reg.random_byte & okk;
                                pc_next = add_y[11:0];
                            end
                            4'hD:
                            begin
                                pc_next = add_y[11:0];
                                vf_next = 1'b0;
                                row_next = '0;
                                if (on == 4'h0)
                                begin
                                    v_next[15] = '0;
                                end
                                else
                                begin
                                    state_next = ST_DRAW_RD;
                                end
                            end
                            4'hE:
                            begin
                                pc_next = add_y[11:0];
                                if (okk == 8'h9E)
                                begin
                                    if (cmd_reg.key_state[vx[3:0]])
                                    begin
                                        add_b = 17'd4;
                                    end
                                end
                                else if (okk == 8'hA1)
                                begin
                                    if (!cmd_reg.key_state[vx[3:0]])
                                    begin
                                        add_b = 17'd4;
                                    end
                                end
                                else
                                begin
                                    ill_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                pc_next = add_y[11:0];
                                case (okk)
                                    8'h07: v_next[ox] = dt_reg;
                                    8'h0A:
                                    begin
                                        if (cmd_reg.key_state != '0)
                                        begin
                                            v_next[ox] = {4'd0, key_hi};
                                        end
                                        else
                                        begin
                                            wait_next = 1'b1;
                                            pc_next = pc_reg;
                                        end
                                    end
                                    8'h15: dt_next = vx;
                                    8'h18: st_next = vx;
                                    8'h1E:
                                    begin
                                        // adder busy with pc; I add done inline
                                        i_next = i_reg + {8'd0, vx};
                                    end
                                    8'h29: i_next = 16'({vx, 2'b00}) + 16'(vx);
                                    8'h33:
                                    begin
                                        bcd_next = '0;
                                        acc_next = vx;
                                        cnt_next = '0;
                                        state_next = ST_BCD;
                                    end
                                    8'h55:
                                    begin
                                        cnt_next = '0;
                                        state_next = ST_STORE;
                                    end
                                    8'h65:
                                    begin
                                        cnt_next = '0;
                                        state_next = ST_LOAD_RD;
                                    end
                                    default: ill_next = 1'b1;
                                endcase
                            end
                        endcase
                    end
                endcase
            end
            ST_MEMRD:
            begin
                m_ra = MAW'(cmd_reg.address);
                state_next = ST_MEMWAIT;
            end
            ST_MEMWAIT:
            begin
                rd_next = m_rd;
                state_next = ST_DONE;
            end
            ST_DRAW_RD:
            begin
                add_a = {1'b0, i_reg};
                add_b = {13'd0, row_reg};
                m_ra = MAW'(add_y);
                cnt_next = '0;
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT:
            begin
                add_a = {1'b0, i_reg};
                add_b = {13'd0, row_reg};
                m_ra = MAW'(add_y);
                bits_next = m_rd;
                state_next = ST_DRAW_PIX;
                // issue first pixel read
                f_a = PAW'(py) * PAW'(SCREEN_COLS) + PAW'(px);
                cnt_next = 4'd8;
            end
            ST_DRAW_PIX:
            begin
                // cnt[3]=1: read issued, cnt[3]=0: write
                f_a = PAW'(py) * PAW'(SCREEN_COLS) + PAW'(px);
                if (cnt_reg[3])
                begin
                    cnt_next = {1'b0, cnt_reg[2:0]};
                end
                else
                begin
                    if (bits_reg[3'd7 - cnt_reg[2:0]])
                    begin
                        f_we = 1'b1;
                        f_wd = ~f_rd;
                        if (f_rd)
                        begin
                            vf_next = 1'b1;
                        end
                    end
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        row_next = row_reg + 1'b1;
                        if (row_reg + 1'b1 == on)
                        begin
                            v_next[15] = {7'd0, vf_reg | (bits_reg[0] & f_rd)};
                            coll_next = vf_reg | (bits_reg[0] & f_rd);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DRAW_RD;
                        end
                    end
                    else
                    begin
                        cnt_next = {1'b1, cnt_reg[2:0] + 3'd1};
                    end
                end
            end
            ST_BCD:
            begin
                add_a = {1'b0, i_reg};
                add_b = {15'd0, bcd_reg};
                m_we = 1'b1;
                m_wa = MAW'(add_y);
                if (bcd_reg == 2'd0)
                begin
                    // hundreds: (x * 41) >> 12 is exact for 0..255
                    bcd_prod = {8'd0, acc_reg} * 16'd41;
                    bcd_dig  = bcd_prod[15:12];
                    m_wd     = {4'd0, bcd_dig};
                    acc_next = acc_reg - {4'd0, bcd_dig} * 8'd100;
                end
                else if (bcd_reg == 2'd1)
                begin
                    // tens: (x * 205) >> 11 is exact for 0..99
                    bcd_prod = {8'd0, acc_reg} * 16'd205;
                    bcd_dig  = bcd_prod[14:11];
                    m_wd     = {4'd0, bcd_dig};
                    acc_next = acc_reg - {4'd0, bcd_dig} * 8'd10;
                end
                else
                begin
                    m_wd = acc_reg;
                end
                bcd_next = bcd_reg + 1'b1;
                if (bcd_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STORE:
            begin
                add_a = {1'b0, i_reg};
                add_b = {13'd0, cnt_reg};
                m_we = 1'b1;
                m_wa = MAW'(add_y);
                m_wd = v_reg[cnt_reg];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ox)
                begin
                    i_next = add_y[15:0] + 16'd1;
                    state_next = ST_DONE;
                end
            end
            ST_LOAD_RD:
            begin
                add_a = {1'b0, i_reg};
                add_b = {13'd0, cnt_reg};
                m_ra = MAW'(add_y);
                state_next = ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT:
            begin
                add_a = {1'b0, i_reg};
                add_b = {13'd0, cnt_reg};
                v_next[cnt_reg] = m_rd;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ox)
                begin
                    i_next = add_y[15:0] + 16'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOAD_RD;
                end
            end
            ST_SCR_RD:
            begin
                f_a = PAW'(srow) * PAW'(SCREEN_COLS) + PAW'(scol);
                state_next = ST_SCR_PIX;
            end
            ST_SCR_PIX:
            begin
                if (scol < 16'(SCREEN_COLS) && f_rd)
                begin
                    rd_next = rd_reg | (8'h80 >> cnt_reg[2:0]);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.next_pc     = pc_reg;
        rsp.waiting_key = wait_reg;
        rsp.collision   = coll_reg;
        rsp.read_value  = rd_reg;
        rsp.delay_value = dt_reg;
        rsp.sound_value = st_reg;
        rsp.illegal     = ill_reg;
    end

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobed twice");
    a_start_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
`endif

endmodule

[src/c8x_ram.sv]
module c8x_ram
    import c8x_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
